### rtl/interrupt_steering_timer_regs_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the interrupt steering and timer-load block.
// Each macro expands to one labeled concurrent assertion on clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef INTERRUPT_STEERING_TIMER_REGS_TOP_ASSERT_SVH
`define INTERRUPT_STEERING_TIMER_REGS_TOP_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define IST_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define IST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg
// Shared types, register offsets and the source bit table.
// ----------------------------------------------------------------------------
package ist_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_EVENT = 2'd2
  } func_e;

  localparam logic [7:0] ADDR_INIT0      = 8'h90;
  localparam logic [7:0] ADDR_IRQ_STEER  = 8'h92;
  localparam logic [7:0] ADDR_FIRQ_STEER = 8'h93;
  localparam logic [7:0] ADDR_TIMER_HI   = 8'h94;
  localparam logic [7:0] ADDR_TIMER_LO   = 8'h95;

  localparam logic [1:0] SRC_KEYBOARD   = 2'd0;
  localparam logic [1:0] SRC_VERTICAL   = 2'd1;
  localparam logic [1:0] SRC_HORIZONTAL = 2'd2;
  localparam logic [1:0] SRC_TIMER      = 2'd3;

  localparam int unsigned TickW = 13;

  typedef struct packed {
    func_e      func;
    logic [7:0] addr;
    logic [7:0] wdata;
    logic [1:0] source;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_fire;
    logic       firq_fire;
  } result_t;

  // Bit that each source owns in the steering and latch registers.
  function automatic logic [7:0] src_bit(input logic [1:0] src);
    logic [7:0] b;
    unique case (src)
      SRC_KEYBOARD:   b = 8'h02;
      SRC_VERTICAL:   b = 8'h08;
      SRC_HORIZONTAL: b = 8'h10;
      SRC_TIMER:      b = 8'h20;
      default:        b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/ist_regmem.sv
// ----------------------------------------------------------------------------
// ist_regmem
// Byte-wide register file with per-entry valid bits and write forwarding.
// ----------------------------------------------------------------------------
module ist_regmem
  import ist_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       we_i,
  input  logic [7:0] waddr_i,
  input  logic [7:0] wdata_i,
  input  logic       re_i,
  input  logic [7:0] raddr_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem_q [256];
  logic [7:0] mem_rd_q;
  logic [255:0] vld_q;
  logic       vld_rd_q;
  logic       hit_q;
  logic [7:0] hit_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      mem_rd_q <= mem_q[raddr_i];
    end
  end

  // An entry never written since reset reads as zero. A read issued in the
  // same cycle as a write to its address returns the new byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      vld_rd_q   <= 1'b0;
      hit_q      <= 1'b0;
      hit_data_q <= 8'h00;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        vld_rd_q   <= vld_q[raddr_i];
        hit_q      <= we_i && (waddr_i == raddr_i);
        hit_data_q <= wdata_i;
      end
    end
  end

  assign rdata_o = hit_q ? hit_data_q : (vld_rd_q ? mem_rd_q : 8'h00);

endmodule

### rtl/ist_steer.sv
// ----------------------------------------------------------------------------
// ist_steer
// Steering, mode, latch and timer-load state with the per-item decode.
// ----------------------------------------------------------------------------
module ist_steer
  import ist_pkg::*;
#(
  parameter int unsigned TIMER_BIAS = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  item_t      item_i,
  input  logic [7:0] mem_rdata_i,
  output result_t    result_o
);

  logic             irq_mode_q, irq_mode_d;
  logic             firq_mode_q, firq_mode_d;
  logic [2:0]       en_q, en_d;
  logic [7:0]       irq_latch_q, irq_latch_d;
  logic [7:0]       firq_latch_q, firq_latch_d;
  logic [7:0]       steer_irq_q, steer_irq_d;
  logic [7:0]       steer_firq_q, steer_firq_d;
  logic [3:0]       tmr_hi_q, tmr_hi_d;
  logic [7:0]       tmr_lo_q, tmr_lo_d;
  logic [TickW-1:0] tick_q, tick_d;

  logic [7:0] bit_w;
  logic [3:0] en_ext;
  logic [7:0] steer_or;

  always_comb begin
    irq_mode_d   = irq_mode_q;
    firq_mode_d  = firq_mode_q;
    en_d         = en_q;
    irq_latch_d  = irq_latch_q;
    firq_latch_d = firq_latch_q;
    steer_irq_d  = steer_irq_q;
    steer_firq_d = steer_firq_q;
    tmr_hi_d     = tmr_hi_q;
    tmr_lo_d     = tmr_lo_q;
    tick_d       = tick_q;
    result_o     = '0;
    bit_w        = src_bit(item_i.source);
    en_ext       = {1'b1, en_q};
    steer_or     = 8'h00;

    unique case (item_i.func)
      FUNC_WRITE: begin
        if (item_i.addr == ADDR_INIT0) begin
          firq_mode_d = item_i.wdata[4];
          irq_mode_d  = item_i.wdata[5];
        end else if (item_i.addr == ADDR_IRQ_STEER ||
                     item_i.addr == ADDR_FIRQ_STEER) begin
          if (item_i.addr == ADDR_IRQ_STEER) begin
            steer_irq_d = item_i.wdata;
          end else begin
            steer_firq_d = item_i.wdata;
          end
          steer_or = steer_irq_d | steer_firq_d;
          en_d     = {steer_or[4], steer_or[3], steer_or[1]};
        end else if (item_i.addr == ADDR_TIMER_HI) begin
          tmr_hi_d = item_i.wdata[3:0];
          tick_d   = TickW'({1'b0, tmr_hi_d, tmr_lo_q}) + TickW'(TIMER_BIAS);
        end else if (item_i.addr == ADDR_TIMER_LO) begin
          tmr_lo_d = item_i.wdata;
        end
      end
      FUNC_READ: begin
        if (item_i.addr == ADDR_IRQ_STEER) begin
          result_o.read_data = irq_latch_q;
          irq_latch_d        = 8'h00;
        end else if (item_i.addr == ADDR_FIRQ_STEER) begin
          result_o.read_data = firq_latch_q;
          firq_latch_d       = 8'h00;
        end else if (item_i.addr == ADDR_TIMER_HI) begin
          result_o.read_data = 8'(tick_q[TickW-1:8]);
        end else if (item_i.addr == ADDR_TIMER_LO) begin
          result_o.read_data = tick_q[7:0];
        end else begin
          result_o.read_data = mem_rdata_i;
        end
      end
      FUNC_EVENT: begin
        // The timer source has no enable bit and is always eligible.
        if (en_ext[item_i.source]) begin
          if (((steer_firq_q & bit_w) != 8'h00) && firq_mode_q) begin
            result_o.firq_fire = 1'b1;
            firq_latch_d       = firq_latch_q | bit_w;
          end else if (((steer_irq_q & bit_w) != 8'h00) && irq_mode_q) begin
            result_o.irq_fire = 1'b1;
            irq_latch_d       = irq_latch_q | bit_w;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_mode_q   <= 1'b0;
      firq_mode_q  <= 1'b0;
      en_q         <= 3'b000;
      irq_latch_q  <= 8'h00;
      firq_latch_q <= 8'h00;
      steer_irq_q  <= 8'h00;
      steer_firq_q <= 8'h00;
      tmr_hi_q     <= 4'h0;
      tmr_lo_q     <= 8'h00;
      tick_q       <= '0;
    end else if (adv_i) begin
      irq_mode_q   <= irq_mode_d;
      firq_mode_q  <= firq_mode_d;
      en_q         <= en_d;
      irq_latch_q  <= irq_latch_d;
      firq_latch_q <= firq_latch_d;
      steer_irq_q  <= steer_irq_d;
      steer_firq_q <= steer_firq_d;
      tmr_hi_q     <= tmr_hi_d;
      tmr_lo_q     <= tmr_lo_d;
      tick_q       <= tick_d;
    end
  end

endmodule

### rtl/interrupt_steering_timer_regs_top.sv
// ----------------------------------------------------------------------------
// interrupt_steering_timer_regs_top: interrupt steering and timer-load unit
// The accepted word sits in the input register, and its result enters the result
// register once that register is free or drained, and is then offered downstream.
// Throughput: one word per cycle. The input stalls only while both stages are
// full and the result register is not drained. Reset clears all control state;
// the register file reads as zero until written.
// ----------------------------------------------------------------------------
`include "interrupt_steering_timer_regs_top_assert.svh"

module interrupt_steering_timer_regs_top
  import ist_pkg::*;
#(
  parameter int unsigned TIMER_BIAS = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata fields from bit 0 up: addr[7:0], wdata[15:8], source[17:16], zero pad.
  input  logic [23:0] s_axis_tdata_i,
  // tuser fields from bit 0 up: func[1:0].
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata fields from bit 0 up: read_data[7:0], irq_fire[8], firq_fire[9], zero pad.
  output logic [15:0] m_axis_tdata_o
);

  // The first stage holds the accepted word while the register file read,
  // issued on acceptance, completes. The second stage is the result register
  // which lets a new word enter while an earlier result waits downstream.
  logic    s1_valid_q, s1_valid_d;
  item_t   s1_q;
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  logic    in_acc;
  logic    out_acc;
  logic    s1_adv;
  item_t   in_item;
  result_t res;
  logic [7:0] mem_rdata;

  assign in_item.func   = func_e'(s_axis_tuser_i);
  assign in_item.addr   = s_axis_tdata_i[7:0];
  assign in_item.wdata  = s_axis_tdata_i[15:8];
  assign in_item.source = s_axis_tdata_i[17:16];

  // The first stage moves on whenever the result register is free or drained.
  assign s1_adv          = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc         = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_acc) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_item;
    end
    if (s1_adv) begin
      out_q <= res;
    end
  end

  // Every write lands in the register file, including the special offsets;
  // reads of the steering and timer offsets are served by the steering unit instead.
  ist_regmem u_regmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (s1_adv && (s1_q.func == FUNC_WRITE)),
    .waddr_i (s1_q.addr),
    .wdata_i (s1_q.wdata),
    .re_i    (in_acc),
    .raddr_i (in_item.addr),
    .rdata_o (mem_rdata)
  );

  ist_steer #(
    .TIMER_BIAS (TIMER_BIAS)
  ) u_steer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (s1_adv),
    .item_i      (s1_q),
    .mem_rdata_i (mem_rdata),
    .result_o    (res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b000000, out_q.firq_fire, out_q.irq_fire, out_q.read_data};

  `IST_ASSERT_SAME(a_ready_when_empty, !s1_valid_q, s_axis_tready_o,
    "input stage empty but not ready")
  `IST_ASSERT_SAME(a_fire_exclusive, s1_valid_q, !(res.irq_fire && res.firq_fire),
    "both interrupt requests raised by one word")
  `IST_ASSERT_SAME(a_fire_only_event, s1_valid_q && (s1_q.func != FUNC_EVENT),
    !res.irq_fire && !res.firq_fire, "interrupt request raised by a non-event word")
  `IST_ASSERT_NEXT(a_accept_fills, in_acc, s1_valid_q,
    "accepted word did not reach the input stage")

endmodule

### bench/ist_reply_checker.sv
// ----------------------------------------------------------------------------
// ist_reply_checker: result checker for the interrupt steering unit
// Watches both stream channels, keeps its own copy of the register file,
// the steering and mode state and the timer counter, predicts the response
// to every accepted word and compares it with the words that come back.
// ----------------------------------------------------------------------------
module ist_reply_checker
  import ist_pkg::*;
#(
  parameter int unsigned TIMER_BIAS = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  // tdata fields from bit 0 up: addr[7:0], wdata[15:8], source[17:16], zero pad.
  input  logic [23:0] s_axis_tdata_i,
  // tuser fields from bit 0 up: func[1:0].
  input  logic [1:0]  s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  // tdata fields from bit 0 up: read_data[7:0], irq_fire[8], firq_fire[9], zero pad.
  input  logic [15:0] m_axis_tdata_i,
  output int unsigned mismatches_o,
  output int unsigned replies_due_o,
  output int unsigned replies_checked_o,
  output int unsigned requests_raised_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]       regs_q [256];
  logic             irq_mode_q;
  logic             firq_mode_q;
  logic [2:0]       src_en_q;
  logic [7:0]       irq_pend_q;
  logic [7:0]       firq_pend_q;
  logic [TickW-1:0] tick_q;
  logic [TickW-1:0] reload_q;
  result_t          responses_due [$];

  // Applies one bus word to the shadow state and returns the response it causes.
  function automatic result_t bus_response(input logic [1:0] fn, input logic [7:0] addr,
                                           input logic [7:0] wdata, input logic [1:0] src);
    result_t     r;
    logic [7:0]  both;
    logic [7:0]  src_mask;
    logic [11:0] raw;
    logic        enabled;
    r = '0;
    case (fn)
      FUNC_WRITE: begin
        regs_q[addr] = wdata;
        raw = {regs_q[ADDR_TIMER_HI][3:0], regs_q[ADDR_TIMER_LO]};
        if (addr == ADDR_INIT0) begin
          firq_mode_q = wdata[4];
          irq_mode_q  = wdata[5];
        end else if (addr == ADDR_IRQ_STEER || addr == ADDR_FIRQ_STEER) begin
          both     = regs_q[ADDR_IRQ_STEER] | regs_q[ADDR_FIRQ_STEER];
          src_en_q = {both[4], both[3], both[1]};
        end else if (addr == ADDR_TIMER_HI) begin
          reload_q = TickW'(raw) + TickW'(TIMER_BIAS);
          tick_q   = reload_q;
        end else if (addr == ADDR_TIMER_LO) begin
          reload_q = TickW'(raw);
        end
      end
      FUNC_READ: begin
        if (addr == ADDR_IRQ_STEER) begin
          r.read_data = irq_pend_q;
          irq_pend_q  = '0;
        end else if (addr == ADDR_FIRQ_STEER) begin
          r.read_data = firq_pend_q;
          firq_pend_q = '0;
        end else if (addr == ADDR_TIMER_HI) begin
          r.read_data = 8'(tick_q >> 8);
        end else if (addr == ADDR_TIMER_LO) begin
          r.read_data = tick_q[7:0];
        end else begin
          r.read_data = regs_q[addr];
        end
      end
      FUNC_EVENT: begin
        case (src)
          SRC_KEYBOARD:   src_mask = 8'h02;
          SRC_VERTICAL:   src_mask = 8'h08;
          SRC_HORIZONTAL: src_mask = 8'h10;
          default:        src_mask = 8'h20;
        endcase
        // The timer has no enable bit; the others need one in either mask.
        enabled = (src == SRC_TIMER) ? 1'b1 : src_en_q[src];
        if (enabled) begin
          if ((regs_q[ADDR_FIRQ_STEER] & src_mask) != 0 && firq_mode_q) begin
            r.firq_fire = 1'b1;
            firq_pend_q = firq_pend_q | src_mask;
          end else if ((regs_q[ADDR_IRQ_STEER] & src_mask) != 0 && irq_mode_q) begin
            r.irq_fire = 1'b1;
            irq_pend_q = irq_pend_q | src_mask;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      foreach (regs_q[i]) regs_q[i] = '0;
      irq_mode_q        = 1'b0;
      firq_mode_q       = 1'b0;
      src_en_q          = '0;
      irq_pend_q        = '0;
      firq_pend_q       = '0;
      tick_q            = '0;
      reload_q          = '0;
      responses_due.delete();
      mismatches_o      = 0;
      replies_checked_o = 0;
      requests_raised_o = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.read_data = m_axis_tdata_i[7:0];
        got.irq_fire  = m_axis_tdata_i[8];
        got.firq_fire = m_axis_tdata_i[9];
        if (responses_due.size() == 0) begin
          if (mismatches_o < 10) begin
            $display("%0t: result word with nothing outstanding: read_data=%02h irq=%0b firq=%0b",
                     $time, got.read_data, got.irq_fire, got.firq_fire);
          end
          mismatches_o++;
        end else begin
          want = responses_due.pop_front();
          if (got.read_data !== want.read_data || got.irq_fire !== want.irq_fire ||
              got.firq_fire !== want.firq_fire) begin
            if (mismatches_o < 10) begin
              $display("%0t: result %0d: expected read_data=%02h irq=%0b firq=%0b, got %02h %0b %0b",
                       $time, replies_checked_o, want.read_data, want.irq_fire, want.firq_fire,
                       got.read_data, got.irq_fire, got.firq_fire);
            end
            mismatches_o++;
          end
          replies_checked_o++;
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        want = bus_response(s_axis_tuser_i, s_axis_tdata_i[7:0], s_axis_tdata_i[15:8],
                            s_axis_tdata_i[17:16]);
        if (want.irq_fire || want.firq_fire) requests_raised_o++;
        responses_due.push_back(want);
      end
    end
    replies_due_o = responses_due.size();
  end

endmodule

### bench/tb_interrupt_steering_timer_regs_top.sv
// ----------------------------------------------------------------------------
// tb_interrupt_steering_timer_regs_top: testbench for the steering unit
// Drives register writes, register reads and interrupt source events into the
// block under three idling patterns, with a long output stall and drain pauses,
// and lets the checker beside the block predict and compare every result word.
// ----------------------------------------------------------------------------
module tb_interrupt_steering_timer_regs_top
  import ist_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BIAS        = 2;
  localparam int unsigned HALF_PERIOD = 4;
  localparam int unsigned RESET_CYCLES = 7;
  // A word code the block does not decode; it must leave all state alone.
  localparam logic [1:0]  FUNC_SPARE  = 2'd3;
  // Random words per phase; a small share of them are spare-code words.
  localparam int unsigned PHASE_WORDS = 420;
  // Cycles the receiver holds tready low while the sender keeps offering.
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned TIMEOUT_NS  = 2_000_000;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // tdata fields from bit 0 up: addr[7:0], wdata[15:8], source[17:16], zero pad.
  logic [23:0] s_axis_tdata_i  = '0;
  // tuser fields from bit 0 up: func[1:0].
  logic [1:0]  s_axis_tuser_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // tdata fields from bit 0 up: read_data[7:0], irq_fire[8], firq_fire[9], zero pad.
  logic [15:0] m_axis_tdata_o;

  int unsigned mismatches;
  int unsigned replies_due;
  int unsigned replies_checked;
  int unsigned requests_raised;
  int unsigned words_sent = 0;

  // Idle chances in percent; the stimulus process changes them per phase.
  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 76;

  always #HALF_PERIOD clk_i = ~clk_i;

  interrupt_steering_timer_regs_top #(
    .TIMER_BIAS (BIAS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  ist_reply_checker #(
    .TIMER_BIAS (BIAS)
  ) reply_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .s_axis_tvalid_i   (s_axis_tvalid_i),
    .s_axis_tready_i   (s_axis_tready_o),
    .s_axis_tdata_i    (s_axis_tdata_i),
    .s_axis_tuser_i    (s_axis_tuser_i),
    .m_axis_tvalid_i   (m_axis_tvalid_o),
    .m_axis_tready_i   (m_axis_tready_i),
    .m_axis_tdata_i    (m_axis_tdata_o),
    .mismatches_o      (mismatches),
    .replies_due_o     (replies_due),
    .replies_checked_o (replies_checked),
    .requests_raised_o (requests_raised)
  );

  // Offers one word and returns at the edge where it is accepted. The valid
  // is only lowered while idling, so a word that follows directly keeps it
  // high without a second assignment in the same time step.
  task automatic send_word(input logic [1:0] fn, input logic [7:0] addr,
                           input logic [7:0] wdata, input logic [1:0] src);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= fn;
    s_axis_tdata_i  <= {6'd0, src, wdata, addr};
    do @(posedge clk_i); while (!s_axis_tready_o);
    words_sent++;
  endtask

  // Stops offering and waits until every predicted result word has returned.
  // The extra edge first lets the checker record the word accepted last.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    wait (replies_due == 0);
    @(posedge clk_i);
  endtask

  // Random words are weighted toward the mode and steering registers and
  // toward source events, so that requests actually fire and latches fill
  // before they are read back. The rest is plain register traffic, timer
  // loads and the spare code.
  task automatic send_random_word();
    int unsigned pick;
    logic [7:0]  addr;
    logic [7:0]  wdata;
    logic [1:0]  src;
    pick  = $urandom_range(99);
    addr  = 8'($urandom);
    wdata = 8'($urandom);
    src   = 2'($urandom);
    if (pick < 30) begin
      send_word(FUNC_EVENT, addr, wdata, src);
    end else if (pick < 45) begin
      case ($urandom_range(2))
        0:       addr = ADDR_INIT0;
        1:       addr = ADDR_IRQ_STEER;
        default: addr = ADDR_FIRQ_STEER;
      endcase
      send_word(FUNC_WRITE, addr, wdata, src);
    end else if (pick < 53) begin
      addr = $urandom_range(1) ? ADDR_TIMER_HI : ADDR_TIMER_LO;
      send_word(FUNC_WRITE, addr, wdata, src);
    end else if (pick < 73) begin
      case ($urandom_range(3))
        0:       addr = ADDR_IRQ_STEER;
        1:       addr = ADDR_FIRQ_STEER;
        2:       addr = ADDR_TIMER_HI;
        default: addr = ADDR_TIMER_LO;
      endcase
      send_word(FUNC_READ, addr, wdata, src);
    end else if (pick < 95) begin
      send_word($urandom_range(1) ? FUNC_READ : FUNC_WRITE, addr, wdata, src);
    end else begin
      send_word(FUNC_SPARE, addr, wdata, src);
    end
  endtask

  // Receiver: random tready, plus one long hold-off early in the run while
  // the sender is still busy, so the block fills up and backs up its input.
  initial begin : receiver
    wait (rst_ni);
    repeat (300) begin
      @(posedge clk_i);
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
    repeat (LONG_HOLD) begin
      @(posedge clk_i);
      m_axis_tready_i <= 1'b0;
    end
    forever begin
      @(posedge clk_i);
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Run timed out with %0d result words outstanding.", replies_due);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening. Both modes on, keyboard and vertical steered to IRQ,
    // horizontal and timer steered to FIRQ, then one event per source.
    send_word(FUNC_WRITE, ADDR_INIT0, 8'h30, SRC_KEYBOARD);
    send_word(FUNC_WRITE, ADDR_IRQ_STEER, 8'h0A, SRC_KEYBOARD);
    send_word(FUNC_WRITE, ADDR_FIRQ_STEER, 8'h30, SRC_KEYBOARD);
    send_word(FUNC_EVENT, 8'h00, 8'h00, SRC_KEYBOARD);
    send_word(FUNC_EVENT, 8'hFF, 8'hFF, SRC_VERTICAL);
    send_word(FUNC_EVENT, 8'h00, 8'h00, SRC_HORIZONTAL);
    send_word(FUNC_EVENT, 8'hFF, 8'hFF, SRC_TIMER);
    // Latch reads clear the latch, so the second IRQ read must return zero.
    send_word(FUNC_READ, ADDR_IRQ_STEER, 8'h00, SRC_KEYBOARD);
    send_word(FUNC_READ, ADDR_IRQ_STEER, 8'h00, SRC_KEYBOARD);
    send_word(FUNC_READ, ADDR_FIRQ_STEER, 8'h00, SRC_KEYBOARD);
    // Timer loads: the low-byte write only touches the reload value, and the
    // second high-byte load of 0xFFF plus the bias carries into bit 12.
    send_word(FUNC_WRITE, ADDR_TIMER_HI, 8'hFF, SRC_KEYBOARD);
    send_word(FUNC_WRITE, ADDR_TIMER_LO, 8'hFF, SRC_KEYBOARD);
    send_word(FUNC_READ, ADDR_TIMER_LO, 8'h00, SRC_KEYBOARD);
    send_word(FUNC_WRITE, ADDR_TIMER_HI, 8'hFF, SRC_KEYBOARD);
    send_word(FUNC_READ, ADDR_TIMER_HI, 8'h00, SRC_KEYBOARD);
    send_word(FUNC_READ, ADDR_TIMER_LO, 8'h00, SRC_KEYBOARD);
    // Plain register file entries at both ends of the address range.
    send_word(FUNC_WRITE, 8'h00, 8'hFF, SRC_TIMER);
    send_word(FUNC_READ, 8'h00, 8'h00, SRC_TIMER);
    send_word(FUNC_WRITE, 8'hFF, 8'hA5, SRC_TIMER);
    send_word(FUNC_READ, 8'hFF, 8'h00, SRC_TIMER);
    send_word(FUNC_READ, ADDR_INIT0, 8'h00, SRC_TIMER);
    // Only IRQ mode on and a source steered both ways: it falls back to IRQ.
    send_word(FUNC_WRITE, ADDR_INIT0, 8'h20, SRC_KEYBOARD);
    send_word(FUNC_WRITE, ADDR_FIRQ_STEER, 8'h02, SRC_KEYBOARD);
    send_word(FUNC_EVENT, 8'h00, 8'h00, SRC_KEYBOARD);
    // Both modes off: the timer event must raise nothing. Then with both
    // masks cleared the keyboard is disabled and raises nothing either.
    send_word(FUNC_WRITE, ADDR_INIT0, 8'h00, SRC_KEYBOARD);
    send_word(FUNC_EVENT, 8'h00, 8'h00, SRC_TIMER);
    send_word(FUNC_WRITE, ADDR_IRQ_STEER, 8'h00, SRC_KEYBOARD);
    send_word(FUNC_WRITE, ADDR_FIRQ_STEER, 8'h00, SRC_KEYBOARD);
    send_word(FUNC_EVENT, 8'h00, 8'h00, SRC_KEYBOARD);
    // The spare code with every field bit set must change nothing.
    send_word(FUNC_SPARE, 8'hFF, 8'hFF, SRC_TIMER);

    // Phase one: sender idles lightly, receiver idles heavily; the long
    // receiver hold-off falls in here.
    repeat (PHASE_WORDS) send_random_word();
    drain_results();

    // Phase two: the other way round.
    send_idle_pct = 76;
    recv_idle_pct = 35;
    repeat (PHASE_WORDS) send_random_word();
    drain_results();

    // Phase three: back-to-back words with the receiver always ready.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (PHASE_WORDS) send_random_word();
    drain_results();

    // Keep clocking to catch any stray result word.
    repeat (8) @(posedge clk_i);

    $display("Sent %0d words (writes, reads, source events, spare codes); checked %0d results.",
             words_sent, replies_checked);
    $display("Predicted %0d interrupt requests across light, heavy and no idling.",
             requests_raised);
    if (mismatches == 0 && replies_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
